>>> src/chkv_pkg.sv
`timescale 1ns / 1ps
package chkv_pkg;

  localparam int unsigned DefSlots = 1024;
  localparam int unsigned KeyW     = 31;
  localparam int unsigned ValW     = 32;

  localparam logic signed [ValW-1:0] NegOne = '1;

  typedef enum logic [1:0] {
    REQ_SEARCH = 2'd0,
    REQ_INSERT = 2'd1,
    REQ_ERASE  = 2'd2
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_NOT_FOUND = 2'd1,
    ST_FULL      = 2'd2
  } status_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_HOME,
    S_READ,
    S_CHECK,
    S_SCAN,
    S_LINK
  } state_e;

  typedef struct packed {
    logic [1:0]             req_type;
    logic [KeyW-1:0]        key;
    logic signed [ValW-1:0] value;
  } req_t;

  typedef struct packed {
    status_e                status;
    logic signed [ValW-1:0] found_value;
  } rsp_t;

endpackage

>>> src/chkv_mem.sv
`timescale 1ns / 1ps
module chkv_mem #(
  parameter int unsigned Width = 75,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> src/chkv_home.sv
`timescale 1ns / 1ps
module chkv_home #(
  parameter int unsigned Slots = chkv_pkg::DefSlots
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           start_i,
  input  logic [chkv_pkg::KeyW-1:0]      key_i,
  output logic                           done_o,
  output logic [$clog2(Slots)-1:0]       home_o
);
  import chkv_pkg::*;

  localparam int unsigned IdxW = $clog2(Slots);

  if ((Slots & (Slots - 1)) == 0) begin : g_pow2
    logic            done_q;
    logic [IdxW-1:0] home_q;

    // home slot is just the low key bits
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        done_q <= 1'b0;
      end else begin
        done_q <= start_i;
      end
    end

    always_ff @(posedge clk_i) begin
      if (start_i) begin
        home_q <= key_i[IdxW-1:0];
      end
    end

    assign done_o = done_q;
    assign home_o = home_q;
  end else begin : g_recip
    localparam int unsigned     Shift  = KeyW + IdxW;
    localparam int unsigned     ProdW  = 2 * KeyW + 1;
    localparam longint unsigned RecipL =
        ((64'd1 << Shift) + 64'(Slots) - 64'd1) / 64'(Slots);
    localparam logic [KeyW:0]   Recip  = (KeyW+1)'(RecipL);
    localparam logic [IdxW-1:0] SlotsI = IdxW'(Slots);

    logic             mul_q, sub_q, done_q;
    logic [KeyW-1:0]  key_q;
    logic [IdxW-1:0]  quo_q;
    logic [IdxW-1:0]  rem_q;
    logic [ProdW-1:0] prod;

    // quotient by reciprocal multiply; only its low bits matter for the remainder
    assign prod = ProdW'(key_q) * ProdW'(Recip);

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        mul_q  <= 1'b0;
        sub_q  <= 1'b0;
        done_q <= 1'b0;
      end else begin
        mul_q  <= start_i;
        sub_q  <= mul_q;
        done_q <= sub_q;
      end
    end

    // remainder is below slots, so the low index bits give it exactly
    always_ff @(posedge clk_i) begin
      if (start_i) begin
        key_q <= key_i;
      end
      quo_q <= prod[Shift +: IdxW];
      rem_q <= key_q[IdxW-1:0] - quo_q * SlotsI;
    end

    assign done_o = done_q;
    assign home_o = rem_q;
  end

endmodule

>>> src/coalesced_hash_key_value_map_core.sv
`timescale 1ns / 1ps
// a search or erase that resolves at the home slot steps through S_HOME, S_READ and S_CHECK
//   after accept; each further chain step reads the slot, then tests it
// an insert that falls back to the free-slot scan reads up to all Slots slots, one slot read
//   per cycle through the single memory read port; Slots not a power of two adds home stages
// throughput: one item at a time, busy high until its result strobe; the receiver cannot stall
// reset: after rst_ni the slot memory is cleared one slot a cycle, busy high until all are clear
module coalesced_hash_key_value_map_core #(
  parameter int unsigned Slots = chkv_pkg::DefSlots
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  output logic           busy,
  input  chkv_pkg::req_t req_i,
  output logic           rsp_valid_o,
  output chkv_pkg::rsp_t rsp_o
);
  import chkv_pkg::*;

  localparam int unsigned IdxW  = $clog2(Slots);
  localparam int unsigned CntW  = $clog2(Slots + 1);
  localparam int unsigned LinkW = IdxW + 1;
  localparam int unsigned EntW  = 1 + KeyW + ValW + LinkW;
  localparam logic [LinkW-1:0] SlotsL = LinkW'(Slots);
  localparam logic [EntW-1:0]  ClrEnt = {1'b0, {KeyW{1'b0}}, {ValW{1'b0}}, {LinkW{1'b1}}};

  state_e          state_q, state_d;
  req_t            req_q, req_d;
  logic [IdxW-1:0] cur_q, cur_d;
  logic [IdxW-1:0] step_q, step_d;
  logic [IdxW-1:0] clr_q, clr_d;
  logic [CntW-1:0] sidx_q, sidx_d;
  logic [IdxW-1:0] pidx_q, pidx_d;
  logic            rd_pend_q, rd_pend_d;
  logic [IdxW-1:0] tail_q, tail_d;
  logic [EntW-1:0] tail_ent_q, tail_ent_d;
  logic [IdxW-1:0] fill_q, fill_d;
  logic            rsp_valid_q, rsp_valid_d;
  rsp_t            rsp_q, rsp_d;

  logic            home_start;
  logic            home_done;
  logic [IdxW-1:0] home_idx;

  logic            mem_we, mem_re;
  logic [IdxW-1:0] mem_waddr, mem_raddr;
  logic [EntW-1:0] mem_wdata, mem_rdata;

  logic                   ent_valid;
  logic [KeyW-1:0]        ent_key;
  logic signed [ValW-1:0] ent_value;
  logic [LinkW-1:0]       ent_link;
  logic                   hit, chain_end, last_step;

  assign ent_valid = mem_rdata[EntW-1];
  assign ent_key   = mem_rdata[LinkW+ValW +: KeyW];
  assign ent_value = mem_rdata[LinkW +: ValW];
  assign ent_link  = mem_rdata[0 +: LinkW];

  assign hit       = ent_valid && (ent_key == req_q.key);
  assign chain_end = ent_link >= SlotsL;
  assign last_step = step_q == IdxW'(Slots - 1);

  chkv_home #(
    .Slots(Slots)
  ) u_home (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(home_start),
    .key_i  (req_i.key),
    .done_o (home_done),
    .home_o (home_idx)
  );

  chkv_mem #(
    .Width(EntW),
    .Depth(Slots)
  ) u_mem (
    .clk_i  (clk_i),
    .we_i   (mem_we),
    .waddr_i(mem_waddr),
    .wdata_i(mem_wdata),
    .re_i   (mem_re),
    .raddr_i(mem_raddr),
    .rdata_o(mem_rdata)
  );

  always_comb begin
    state_d     = state_q;
    req_d       = req_q;
    cur_d       = cur_q;
    step_d      = step_q;
    clr_d       = clr_q;
    sidx_d      = sidx_q;
    pidx_d      = pidx_q;
    rd_pend_d   = rd_pend_q;
    tail_d      = tail_q;
    tail_ent_d  = tail_ent_q;
    fill_d      = fill_q;
    rsp_valid_d = 1'b0;
    rsp_d       = '{status: ST_NOT_FOUND, found_value: NegOne};
    home_start  = 1'b0;
    mem_we      = 1'b0;
    mem_waddr   = cur_q;
    mem_wdata   = ClrEnt;
    mem_re      = 1'b0;
    mem_raddr   = cur_q;

    unique case (state_q)
      S_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_q;
        clr_d     = clr_q + 1'b1;
        if (clr_q == IdxW'(Slots - 1)) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (start) begin
          req_d  = req_i;
          step_d = '0;
          unique case (req_i.req_type)
            REQ_SEARCH, REQ_INSERT, REQ_ERASE: begin
              home_start = 1'b1;
              state_d    = S_HOME;
            end
            // unknown request: answered at once, nothing changes
            default: begin
              rsp_valid_d = 1'b1;
            end
          endcase
        end
      end
      S_HOME: begin
        if (home_done) begin
          cur_d   = home_idx;
          state_d = S_READ;
        end
      end
      S_READ: begin
        mem_re  = 1'b1;
        state_d = S_CHECK;
      end
      S_CHECK: begin
        if (req_q.req_type == REQ_INSERT) begin
          priority if (!ent_valid) begin
            // empty slot on the chain: take it, its old link stays
            mem_we          = 1'b1;
            mem_wdata       = {1'b1, req_q.key, req_q.value, ent_link};
            rsp_valid_d     = 1'b1;
            rsp_d.status    = ST_OK;
            state_d         = S_IDLE;
          end else if (chain_end) begin
            tail_d     = cur_q;
            tail_ent_d = mem_rdata;
            sidx_d     = '0;
            rd_pend_d  = 1'b0;
            state_d    = S_SCAN;
          end else if (last_step) begin
            rsp_valid_d  = 1'b1;
            rsp_d.status = ST_FULL;
            state_d      = S_IDLE;
          end else begin
            cur_d   = ent_link[IdxW-1:0];
            step_d  = step_q + 1'b1;
            state_d = S_READ;
          end
        end else begin
          priority if (hit) begin
            rsp_valid_d  = 1'b1;
            rsp_d.status = ST_OK;
            if (req_q.req_type == REQ_SEARCH) begin
              rsp_d.found_value = ent_value;
            end else begin
              // erase only drops the valid bit
              mem_we    = 1'b1;
              mem_wdata = {1'b0, mem_rdata[EntW-2:0]};
            end
            state_d = S_IDLE;
          end else if (chain_end || last_step) begin
            rsp_valid_d = 1'b1;
            state_d     = S_IDLE;
          end else begin
            cur_d   = ent_link[IdxW-1:0];
            step_d  = step_q + 1'b1;
            state_d = S_READ;
          end
        end
      end
      S_SCAN: begin
        // reads issued back to back, each tested the cycle after
        priority if (rd_pend_q && !ent_valid) begin
          mem_we    = 1'b1;
          mem_waddr = pidx_q;
          mem_wdata = {1'b1, req_q.key, req_q.value, ent_link};
          fill_d    = pidx_q;
          state_d   = S_LINK;
        end else if (sidx_q == CntW'(Slots)) begin
          rsp_valid_d  = 1'b1;
          rsp_d.status = ST_FULL;
          state_d      = S_IDLE;
        end else begin
          mem_re    = 1'b1;
          mem_raddr = sidx_q[IdxW-1:0];
          pidx_d    = sidx_q[IdxW-1:0];
          sidx_d    = sidx_q + 1'b1;
          rd_pend_d = 1'b1;
        end
      end
      S_LINK: begin
        mem_we       = 1'b1;
        mem_waddr    = tail_q;
        mem_wdata    = {tail_ent_q[EntW-1:LinkW], 1'b0, fill_q};
        rsp_valid_d  = 1'b1;
        rsp_d.status = ST_OK;
        state_d      = S_IDLE;
      end
      default: begin
        state_d = S_CLEAR;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      step_q      <= '0;
      sidx_q      <= '0;
      rd_pend_q   <= 1'b0;
      rsp_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      clr_q       <= clr_d;
      step_q      <= step_d;
      sidx_q      <= sidx_d;
      rd_pend_q   <= rd_pend_d;
      rsp_valid_q <= rsp_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    req_q      <= req_d;
    cur_q      <= cur_d;
    pidx_q     <= pidx_d;
    tail_q     <= tail_d;
    tail_ent_q <= tail_ent_d;
    fill_q     <= fill_d;
    rsp_q      <= rsp_d;
  end

  assign busy        = state_q != S_IDLE;
  assign rsp_valid_o = rsp_valid_q;
  assign rsp_o       = rsp_q;

endmodule

>>> src/chkv_checker.sv
`timescale 1ns / 1ps
module chkv_checker (
  input logic           clk_i,
  input logic           rst_ni,
  input logic           start,
  input logic           busy,
  input chkv_pkg::req_t req_i,
  input logic           rsp_valid_o,
  input chkv_pkg::rsp_t rsp_o
);
  import chkv_pkg::*;

  logic accept;
  assign accept = start && !busy;

  // a result strobe is never repeated without a fresh item
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && !accept) |=> !rsp_valid_o)
    else $error("result strobe without an accepted item");

  // results only come out once the block has gone idle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> !busy)
    else $error("result shown while busy");

  // an accepted item either keeps the block busy or answers at once
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (busy || rsp_valid_o))
    else $error("accepted item dropped");

  // every result whose status is not OK carries -1
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && rsp_o.status != ST_OK) |-> rsp_o.found_value == NegOne)
    else $error("found_value not -1 on a miss");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_o |-> (rsp_o.status == ST_OK || rsp_o.status == ST_NOT_FOUND
                     || rsp_o.status == ST_FULL))
    else $error("bad status code");

endmodule

bind coalesced_hash_key_value_map_core chkv_checker u_chkv_checker (.*);
